### sv/ges_pkg.sv
// Shared types and constants for the GPIO encoder and sonar unit.
package ges_pkg;

  localparam int PORT_COUNT = 16;
  localparam int PORT_W     = $clog2(PORT_COUNT);
  localparam int TIME_WIDTH = 32;
  localparam int CNT_W      = 32;
  localparam int DELAY_W    = 20;
  localparam int CMD_W      = 4;
  localparam int PORT_IN_W  = 5;
  localparam int RV_W       = 32;

  localparam logic [DELAY_W-1:0] REJAM_RESET = 20'd10000;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_ENC   = 2'd1,
    KIND_SONAR = 2'd2
  } kind_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVENT       = 4'd0,
    CMD_DIR         = 4'd2,
    CMD_LEVEL       = 4'd3,
    CMD_CLAIM_ENC   = 4'd4,
    CMD_RELEASE_ENC = 4'd5,
    CMD_CLEAR_CNT   = 4'd6,
    CMD_READ_CNT    = 4'd7,
    CMD_READ_PIN    = 4'd8,
    CMD_CLAIM_SONAR = 4'd9,
    CMD_RING        = 4'd10,
    CMD_READ_ECHO   = 4'd11,
    CMD_JAM         = 4'd12,
    CMD_READ_JAM    = 4'd13
  } cmd_t;

  // Per-lane update controls from the merge stage
  typedef struct packed {
    logic  due_ring;
    logic  cmd_ring;
    logic  edge_hit;
    logic  clr_cnt;
    logic  set_kind;
    kind_t kind_val;
  } lane_ctrl_t;

  // Per-lane state seen by the merge stage
  typedef struct packed {
    kind_t                 kind;
    logic [CNT_W-1:0]      count;
    logic [TIME_WIDTH-1:0] echo;
  } lane_stat_t;

  // One result item
  typedef struct packed {
    logic [RV_W-1:0]       read_value;
    logic                  accepted;
    logic [PORT_COUNT-1:0] direction_bits;
    logic [PORT_COUNT-1:0] level_bits;
    logic                  ring_fired;
    logic [PORT_W-1:0]     ring_port;
  } res_t;

endpackage

### sv/ges_lane.sv
// One port lane: kind, edge count, echo time and ring start of a single port.
module ges_lane import ges_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lane_ctrl_t            ctl,
  input  logic [TIME_WIDTH-1:0] ts,
  output lane_stat_t            stat
);

  kind_t                 kind_r, kind_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] echo_r, echo_nxt;
  logic [TIME_WIDTH-1:0] ping_r, ping_nxt;
  logic [TIME_WIDTH-1:0] ping_eff;
  logic                  ring;

  // Work out the lane update; a due re-ring lands before the command
  always_comb begin
    ring     = ctl.due_ring | ctl.cmd_ring;
    ping_eff = ctl.due_ring ? ts : ping_r;
    kind_nxt = ctl.set_kind ? ctl.kind_val : kind_r;

    if (ctl.clr_cnt) begin
      cnt_nxt = '0;
    end else if (ctl.edge_hit && kind_r == KIND_ENC) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end

    if (ctl.edge_hit && kind_r == KIND_SONAR) begin
      echo_nxt = ts - ping_eff;
    end else if (ring) begin
      echo_nxt = '0;
    end else begin
      echo_nxt = echo_r;
    end

    ping_nxt = ring ? ts : ping_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_PLAIN;
      cnt_r  <= '0;
      echo_r <= '0;
      ping_r <= '0;
    end else begin
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
      echo_r <= echo_nxt;
      ping_r <= ping_nxt;
    end
  end

  // Show the echo as it reads after a due re-ring
  assign stat.kind  = kind_r;
  assign stat.count = cnt_r;
  assign stat.echo  = ctl.due_ring ? '0 : echo_r;

endmodule

### sv/ges_merge.sv
// Command decode, shared port registers and merge of the lane results.
module ges_merge import ges_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic [CMD_W-1:0]                  cmd,
  input  logic [PORT_IN_W-1:0]              port,
  input  logic                              value,
  input  logic [PORT_COUNT-1:0]             edge_status,
  input  logic [TIME_WIDTH-1:0]             ts,
  input  logic                              cfg_we,
  input  logic [DELAY_W-1:0]                cfg_data,
  input  lane_stat_t [PORT_COUNT-1:0]       lane_stat,
  output lane_ctrl_t [PORT_COUNT-1:0]       lane_ctl,
  output res_t                              res
);

  logic [PORT_COUNT-1:0] dir_r, dir_nxt;
  logic [PORT_COUNT-1:0] lvl_r, lvl_nxt;
  logic [PORT_COUNT-1:0] irq_r, irq_nxt;
  logic                  jam_on_r, jam_on_nxt;
  logic [PORT_W-1:0]     jam_tgt_r, jam_tgt_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIME_WIDTH-1:0] dl_r, dl_nxt;
  logic [DELAY_W-1:0]    delay_r;

  logic                  ok;
  logic [PORT_W-1:0]     p;
  logic [PORT_W-1:0]     p_odd;
  logic [PORT_W-1:0]     tgt_odd;
  kind_t                 kind_p;
  logic [PORT_COUNT-1:0] ring_ok;
  logic [PORT_COUNT-1:0] masked;
  logic [TIME_WIDTH-1:0] due_diff;
  logic                  due;
  logic                  due_fire;
  logic                  cmd_fire;
  logic                  jam_hit;
  logic [RV_W-1:0]       rv;
  logic                  acc;

  always_comb begin
    ok       = (port < PORT_IN_W'(PORT_COUNT));
    p        = port[PORT_W-1:0];
    p_odd    = {p[PORT_W-1:1], 1'b1};
    tgt_odd  = {jam_tgt_r[PORT_W-1:1], 1'b1};
    kind_p   = lane_stat[p].kind;
    masked   = edge_status & irq_r;
    due_diff = ts - dl_r;
    due      = pend_r && !due_diff[TIME_WIDTH-1];

    // Mark even sonar ports that can ring
    for (int i = 0; i < PORT_COUNT; i++) begin
      ring_ok[i] = (lane_stat[i].kind == KIND_SONAR) && ((i % 2) == 0)
                   && (i + 1 < PORT_COUNT);
    end
    due_fire = due && jam_on_r && ring_ok[jam_tgt_r];

    dir_nxt     = dir_r;
    lvl_nxt     = lvl_r;
    irq_nxt     = irq_r;
    jam_on_nxt  = jam_on_r;
    jam_tgt_nxt = jam_tgt_r;
    pend_nxt    = pend_r && !due;
    dl_nxt      = dl_r;
    rv          = '0;
    acc         = 1'b0;
    cmd_fire    = 1'b0;
    jam_hit     = 1'b0;

    // Apply the due re-ring first
    if (due_fire) begin
      lvl_nxt[tgt_odd] = 1'b0;
    end

    for (int i = 0; i < PORT_COUNT; i++) begin
      lane_ctl[i]          = '0;
      lane_ctl[i].kind_val = KIND_PLAIN;
      lane_ctl[i].due_ring = due_fire && (jam_tgt_r == PORT_W'(i));
    end

    case (cmd_t'(cmd))
      CMD_EVENT: begin
        for (int i = 0; i < PORT_COUNT; i++) begin
          lane_ctl[i].edge_hit = masked[i];
          if (masked[i] && lane_stat[i].kind == KIND_SONAR && jam_on_r
              && jam_tgt_r == PORT_W'(i)) begin
            jam_hit = 1'b1;
          end
        end
        if (jam_hit) begin
          pend_nxt = 1'b1;
          dl_nxt   = ts + TIME_WIDTH'(delay_r);
        end
        acc = 1'b1;
      end
      CMD_DIR: begin
        if (ok && kind_p == KIND_PLAIN) begin
          dir_nxt[p] = value;
          acc        = 1'b1;
        end
      end
      CMD_LEVEL: begin
        if (ok) begin
          lvl_nxt[p] = value;
          acc        = 1'b1;
        end
      end
      CMD_CLAIM_ENC: begin
        if (ok && kind_p != KIND_SONAR) begin
          lane_ctl[p].set_kind = 1'b1;
          lane_ctl[p].kind_val = KIND_ENC;
          dir_nxt[p]           = 1'b0;
          irq_nxt[p]           = 1'b1;
          acc                  = 1'b1;
        end
      end
      CMD_RELEASE_ENC: begin
        if (ok && kind_p == KIND_ENC) begin
          lane_ctl[p].set_kind = 1'b1;
          lane_ctl[p].kind_val = KIND_PLAIN;
          irq_nxt[p]           = 1'b0;
          acc                  = 1'b1;
        end
      end
      CMD_CLEAR_CNT: begin
        if (ok) begin
          lane_ctl[p].clr_cnt = 1'b1;
          acc                 = 1'b1;
        end
      end
      CMD_READ_CNT: begin
        if (ok) begin
          rv  = RV_W'(lane_stat[p].count);
          acc = 1'b1;
        end
      end
      CMD_READ_PIN: begin
        if (ok) begin
          rv  = {{(RV_W-1){1'b0}}, ~lvl_nxt[p]};
          acc = 1'b1;
        end
      end
      CMD_CLAIM_SONAR: begin
        if (ok && !p[0] && kind_p != KIND_ENC) begin
          lane_ctl[p].set_kind     = 1'b1;
          lane_ctl[p].kind_val     = KIND_SONAR;
          lane_ctl[p_odd].set_kind = 1'b1;
          lane_ctl[p_odd].kind_val = KIND_SONAR;
          dir_nxt[p]               = 1'b0;
          lvl_nxt[p]               = 1'b0;
          dir_nxt[p_odd]           = 1'b1;
          lvl_nxt[p_odd]           = 1'b0;
          irq_nxt[p]               = 1'b1;
          acc                      = 1'b1;
        end
      end
      CMD_RING: begin
        if (ok && ring_ok[p]) begin
          cmd_fire = 1'b1;
          acc      = 1'b1;
        end
      end
      CMD_READ_ECHO: begin
        if (ok && kind_p == KIND_SONAR) begin
          rv  = RV_W'(lane_stat[p].echo);
          acc = 1'b1;
        end
      end
      CMD_JAM: begin
        if (!value) begin
          jam_on_nxt = 1'b0;
          acc        = 1'b1;
        end else if (ok) begin
          jam_on_nxt  = 1'b1;
          jam_tgt_nxt = p;
          cmd_fire    = ring_ok[p];
          acc         = 1'b1;
        end
      end
      CMD_READ_JAM: begin
        rv  = jam_on_r ? RV_W'(jam_tgt_r) : RV_W'(PORT_COUNT);
        acc = 1'b1;
      end
      default: begin
      end
    endcase

    // Ring from the command itself
    if (cmd_fire) begin
      lane_ctl[p].cmd_ring = 1'b1;
      lvl_nxt[p_odd]       = 1'b0;
    end

    // Drop all lane updates when no request moves
    if (!fire) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        lane_ctl[i] = '0;
      end
    end

    res.read_value     = rv;
    res.accepted       = acc;
    res.direction_bits = dir_nxt;
    res.level_bits     = lvl_nxt;
    res.ring_fired     = cmd_fire | due_fire;
    if (cmd_fire) begin
      res.ring_port = p_odd;
    end else if (due_fire) begin
      res.ring_port = tgt_odd;
    end else begin
      res.ring_port = '0;
    end
  end

  // Hold shared state; advance it on each request taken from the input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= '0;
      lvl_r     <= '0;
      irq_r     <= '0;
      jam_on_r  <= 1'b0;
      jam_tgt_r <= '0;
      pend_r    <= 1'b0;
      dl_r      <= '0;
    end else if (fire) begin
      dir_r     <= dir_nxt;
      lvl_r     <= lvl_nxt;
      irq_r     <= irq_nxt;
      jam_on_r  <= jam_on_nxt;
      jam_tgt_r <= jam_tgt_nxt;
      pend_r    <= pend_nxt;
      dl_r      <= dl_nxt;
    end
  end

  // Hold the rejam delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= REJAM_RESET;
    end else if (cfg_we) begin
      delay_r <= cfg_data;
    end
  end

endmodule

### sv/ges_outbuf.sv
// Output register with a skid entry between the result and input channels.
module ges_outbuf import ges_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  input  logic out_stall,
  output logic out_valid,
  output res_t dout,
  output logic full
);

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  // Steer each request into the output register or the skid entry
  always_comb begin
    take       = main_v_r && !out_stall;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_nxt   = din;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = din;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign dout      = main_r;
  assign full      = skid_v_r;

endmodule

### sv/gpio_encoder_sonar_unit.sv
// Each result is registered, in the output register or else the skid entry.
// Throughput: one request per cycle unless stalled; all sixteen lanes update at once.
// A two-entry output buffer lets one request in while a result waits to be taken.
// Reset: synchronous, active low; every port goes plain, all counts and times clear,
// the rejam delay returns to 10000, and requests are taken in the next cycle.
module gpio_encoder_sonar_unit import ges_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [PORT_IN_W-1:0]  in_port,
  input  logic                  in_value,
  input  logic [PORT_COUNT-1:0] in_edge_status,
  input  logic [TIME_WIDTH-1:0] in_timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RV_W-1:0]       out_read_value,
  output logic                  out_accepted,
  output logic [PORT_COUNT-1:0] out_direction_bits,
  output logic [PORT_COUNT-1:0] out_level_bits,
  output logic                  out_ring_fired,
  output logic [PORT_W-1:0]     out_ring_port,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DELAY_W-1:0]    cfg_data
);

  lane_ctrl_t [PORT_COUNT-1:0] lane_ctl;
  lane_stat_t [PORT_COUNT-1:0] lane_stat;
  res_t                        res;
  res_t                        dout;
  logic                        full;
  logic                        fire;

  assign fire      = in_valid && !full;
  assign in_stall  = full;
  assign cfg_ready = 1'b1;

  // Port lanes
  for (genvar g = 0; g < PORT_COUNT; g++) begin : g_lane
    ges_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl[g]),
      .ts   (in_timestamp),
      .stat (lane_stat[g])
    );
  end

  // Decode and merge
  ges_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .cmd        (in_cmd),
    .port       (in_port),
    .value      (in_value),
    .edge_status(in_edge_status),
    .ts         (in_timestamp),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .lane_stat  (lane_stat),
    .lane_ctl   (lane_ctl),
    .res        (res)
  );

  // Result buffer
  ges_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .din      (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .dout     (dout),
    .full     (full)
  );

  assign out_read_value     = dout.read_value;
  assign out_accepted       = dout.accepted;
  assign out_direction_bits = dout.direction_bits;
  assign out_level_bits     = dout.level_bits;
  assign out_ring_fired     = dout.ring_fired;
  assign out_ring_port      = dout.ring_port;

endmodule
